// File: rtl/stereo_biquad_cascade_unit_defines.svh
`ifndef STEREO_BIQUAD_CASCADE_UNIT_DEFINES_SVH
`define STEREO_BIQUAD_CASCADE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante; off while in reset.
`define SBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante; off while in reset.
`define SBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sbc_pkg.sv
package sbc_pkg;

   localparam int MAX_SECTIONS_DEF = 4;
   localparam int STATE_BITS_DEF   = 40;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int COEF_FRAC  = 30;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Signal magnitude is padded to two multiplier halves.
   localparam int HALF_W  = 32;
   localparam int MAG_W   = 2 * HALF_W;
   localparam int PPROD_W = HALF_W + COEF_W;
   localparam int PROD_W  = MAG_W + COEF_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0,
      CSR_B1,
      CSR_B2,
      CSR_A1,
      CSR_A2,
      CSR_COUNT
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_ACC,
      ST_ROUND
   } state_type;

   typedef enum logic [2:0] {
      OP_B0,
      OP_B1,
      OP_A1,
      OP_D1,
      OP_B2,
      OP_A2
   } op_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic [COUNT_W-1:0]       count;
   } cfg_type;

   typedef struct packed {
      logic                     start;
      logic                     negate;
      logic signed [COEF_W-1:0] coef;
   } mul_req_type;

endpackage

// File: rtl/sbc_if.sv
interface sbc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sbc_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [sbc_pkg::SAMPLE_W-1:0] right_sample;
   logic                                first_sample;

   modport source (output valid, left_sample, right_sample, first_sample, input ready);
   modport sink (input valid, left_sample, right_sample, first_sample, output ready);
endinterface

interface sbc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sbc_pkg::SAMPLE_W-1:0] left_out;
   logic signed [sbc_pkg::SAMPLE_W-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sbc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sbc_pkg::CSR_IDX_W-1:0]        index;
   logic [sbc_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sbc_mul.sv
`include "stereo_biquad_cascade_unit_defines.svh"

module sbc_mul #(
   parameter int STATE_BITS = sbc_pkg::STATE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sbc_pkg::mul_req_type         mul_req,
   input  logic signed [STATE_BITS-1:0] operand,
   output logic signed [STATE_BITS-1:0] product,
   output logic                         done,
   output logic                         busy
);

   localparam int SB     = STATE_BITS;
   localparam int RND_W  = sbc_pkg::PROD_W - sbc_pkg::COEF_FRAC;
   localparam int STAGES = 5;
   localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [sbc_pkg::PROD_W-1:0] RND_ONE =
      sbc_pkg::PROD_W'(1) << (sbc_pkg::COEF_FRAC - 1);

   logic [STAGES-1:0]                 stage_ff, stage_in;
   logic [sbc_pkg::MAG_W-1:0]         mag_a_ff, mag_a_in;
   logic [sbc_pkg::COEF_W-1:0]        mag_c_ff, mag_c_in;
   logic                              neg_ff, neg_in;
   logic [sbc_pkg::PPROD_W-1:0]       prod_ff, prod_in;
   logic [sbc_pkg::PPROD_W-1:0]       lo_ff;
   logic [RND_W-1:0]                  rnd_ff, rnd_in;
   logic signed [SB-1:0]              q_ff, q_in;

   logic [SB:0]                       op_ext, op_abs;
   logic [sbc_pkg::COEF_W:0]          c_ext, c_abs;
   logic [sbc_pkg::HALF_W-1:0]        mul_a;
   logic [sbc_pkg::PROD_W-1:0]        sum;
   logic [RND_W-1:0]                  lim, mag_sat;
   logic [SB-1:0]                     mag_sb;

   // Sign-magnitude split of both operands.
   always_comb begin
      op_ext   = {operand[SB-1], operand};
      op_abs   = operand[SB-1] ? (SB+1)'(0) - op_ext : op_ext;
      c_ext    = {mul_req.coef[sbc_pkg::COEF_W-1], mul_req.coef};
      c_abs    = mul_req.coef[sbc_pkg::COEF_W-1] ?
                 (sbc_pkg::COEF_W+1)'(0) - c_ext : c_ext;
      mag_a_in = sbc_pkg::MAG_W'(op_abs[SB-1:0]);
      mag_c_in = c_abs[sbc_pkg::COEF_W-1:0];
      neg_in   = operand[SB-1] ^ mul_req.coef[sbc_pkg::COEF_W-1] ^ mul_req.negate;
   end

   // One 32x32 multiplier: low half first, high half next.
   assign mul_a   = stage_ff[0] ? mag_a_ff[sbc_pkg::HALF_W-1:0]
                                : mag_a_ff[sbc_pkg::MAG_W-1:sbc_pkg::HALF_W];
   assign prod_in = sbc_pkg::PPROD_W'(mul_a) * sbc_pkg::PPROD_W'(mag_c_ff);

   // Join halves, round half away from zero on the magnitude, drop the fraction.
   always_comb begin
      sum    = {prod_ff, sbc_pkg::HALF_W'(0)} + sbc_pkg::PROD_W'(lo_ff) + RND_ONE;
      rnd_in = sum[sbc_pkg::PROD_W-1:sbc_pkg::COEF_FRAC];
   end

   // Saturate the magnitude, then apply the sign.
   always_comb begin
      lim     = RND_W'(SMAX) + RND_W'(neg_ff);
      mag_sat = (rnd_ff > lim) ? lim : rnd_ff;
      mag_sb  = mag_sat[SB-1:0];
      q_in    = neg_ff ? -mag_sb : mag_sb;
   end

   assign stage_in = {stage_ff[STAGES-2:0], mul_req.start};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         mag_a_ff <= mag_a_in;
         mag_c_ff <= mag_c_in;
         neg_ff   <= neg_in;
      end
      if (stage_ff[0] || stage_ff[1]) begin
         prod_ff <= prod_in;
      end
      if (stage_ff[1]) begin
         lo_ff <= prod_ff;
      end
      if (stage_ff[2]) begin
         rnd_ff <= rnd_in;
      end
      if (stage_ff[3]) begin
         q_ff <= q_in;
      end
   end

   assign product = q_ff;
   assign done    = stage_ff[STAGES-1];
   assign busy    = |stage_ff[STAGES-2:0];

   `SBC_ASSERT_NOW(a_mul_start_idle, clock, reset, mul_req.start, !busy, "multiply started while busy")
   `SBC_ASSERT_NOW(a_mul_single_op, clock, reset, 1'b1, $onehot0(stage_ff), "two products in flight")

endmodule

// File: rtl/sbc_core.sv
`include "stereo_biquad_cascade_unit_defines.svh"

module sbc_core #(
   parameter int MAX_SECTIONS = sbc_pkg::MAX_SECTIONS_DEF,
   parameter int STATE_BITS   = sbc_pkg::STATE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sbc_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [sbc_pkg::SAMPLE_W-1:0] in_left,
   input  logic signed [sbc_pkg::SAMPLE_W-1:0] in_right,
   input  logic                                in_first,
   input  logic                                out_free,
   output logic                                out_push,
   output logic signed [sbc_pkg::SAMPLE_W-1:0] out_left,
   output logic signed [sbc_pkg::SAMPLE_W-1:0] out_right,
   output sbc_pkg::mul_req_type                mul_req,
   output logic signed [STATE_BITS-1:0]        mul_operand,
   input  logic signed [STATE_BITS-1:0]        mul_product,
   input  logic                                mul_done
);

   localparam int SB    = STATE_BITS;
   localparam int FRAC  = STATE_BITS - 24;
   localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = sbc_pkg::COUNT_W + 1;
   localparam logic signed [SB-1:0] SMAX    = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN    = ~SMAX;
   localparam logic signed [SB-1:0] RND_HALF = SB'((64'(1) << FRAC) >> 1);
   localparam logic signed [SB-1:0] OUT_MAX = SB'((1 << (sbc_pkg::SAMPLE_W - 1)) - 1);
   localparam logic signed [SB-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic [CNT_W-1:0]     MAX_CNT = CNT_W'(MAX_SECTIONS);

   function automatic logic signed [SB-1:0] sat_add(logic signed [SB-1:0] a,
                                                    logic signed [SB-1:0] b);
      logic signed [SB:0] s;
      s = (SB+1)'(a) + (SB+1)'(b);
      if (s[SB] != s[SB-1]) begin
         sat_add = s[SB] ? SMIN : SMAX;
      end else begin
         sat_add = s[SB-1:0];
      end
   endfunction

   function automatic logic signed [SB-1:0] from_sample(
      logic signed [sbc_pkg::SAMPLE_W-1:0] s);
      from_sample = SB'(s) <<< FRAC;
   endfunction

   // Round half up, floor shift, clamp to the sample range.
   function automatic logic signed [sbc_pkg::SAMPLE_W-1:0] to_sample(
      logic signed [SB-1:0] v);
      logic signed [SB-1:0] t;
      logic signed [SB-1:0] r;
      t = sat_add(v, RND_HALF);
      r = t >>> FRAC;
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
      end
      to_sample = r[sbc_pkg::SAMPLE_W-1:0];
   endfunction

   sbc_pkg::state_type state_ff, state_in;
   sbc_pkg::op_type    op_ff, op_in;
   logic               ch_ff, ch_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;

   logic signed [SB-1:0] x_ff, x_in;
   logic signed [SB-1:0] y_ff, y_in;
   logic signed [SB-1:0] t_ff, t_in;
   logic signed [sbc_pkg::SAMPLE_W-1:0] right_hold_ff, right_hold_in;
   logic signed [sbc_pkg::SAMPLE_W-1:0] left_res_ff, left_res_in;

   logic signed [SB-1:0] d1_ff [2][MAX_SECTIONS];
   logic signed [SB-1:0] d2_ff [2][MAX_SECTIONS];

   logic                 in_accept, clear_all, d1_we, d2_we, sec_done;
   logic [CNT_W-1:0]     n_eff;
   logic [SEC_W-1:0]     sec_last;
   logic signed [SB-1:0] d1_rd, d2_rd, add_a, add_b, add_sum;
   logic signed [sbc_pkg::SAMPLE_W-1:0] rnd_sample;

   // Section count: zero runs one section, large values clamp to the maximum.
   always_comb begin
      n_eff = CNT_W'(cfg.count);
      if (n_eff == '0) begin
         n_eff = CNT_W'(1);
      end else if (n_eff > MAX_CNT) begin
         n_eff = MAX_CNT;
      end
      sec_last = SEC_W'(n_eff - CNT_W'(1));
   end

   assign sec_done   = (sec_ff == sec_last);
   assign in_accept  = in_valid && in_ready;
   assign clear_all  = in_accept && in_first;
   assign d1_rd      = d1_ff[ch_ff][sec_ff];
   assign d2_rd      = d2_ff[ch_ff][sec_ff];
   assign rnd_sample = to_sample(x_ff);

   // Shared saturating adder.
   always_comb begin
      add_a = mul_product;
      add_b = '0;
      case (op_ff) inside
         sbc_pkg::OP_B0: add_b = d1_rd;
         sbc_pkg::OP_A1, sbc_pkg::OP_A2: add_b = t_ff;
         sbc_pkg::OP_D1: begin
            add_a = t_ff;
            add_b = d2_rd;
         end
         default: add_b = '0;
      endcase
   end
   assign add_sum = sat_add(add_a, add_b);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbc_pkg::ST_IDLE: begin
            if (in_valid) state_in = sbc_pkg::ST_MUL_GO;
         end
         sbc_pkg::ST_MUL_GO: state_in = sbc_pkg::ST_MUL_WAIT;
         sbc_pkg::ST_MUL_WAIT: begin
            if (mul_done) state_in = sbc_pkg::ST_ACC;
         end
         sbc_pkg::ST_ACC: begin
            if (op_ff == sbc_pkg::OP_A1) begin
               state_in = sbc_pkg::ST_ACC;
            end else if (op_ff == sbc_pkg::OP_A2 && sec_done) begin
               state_in = sbc_pkg::ST_ROUND;
            end else begin
               state_in = sbc_pkg::ST_MUL_GO;
            end
         end
         sbc_pkg::ST_ROUND: begin
            if (!ch_ff) begin
               state_in = sbc_pkg::ST_MUL_GO;
            end else if (out_free) begin
               state_in = sbc_pkg::ST_IDLE;
            end
         end
         default: state_in = sbc_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshakes, multiplier request, delay writes.
   always_comb begin
      in_ready       = (state_ff == sbc_pkg::ST_IDLE);
      out_push       = (state_ff == sbc_pkg::ST_ROUND) && ch_ff && out_free;
      d1_we          = (state_ff == sbc_pkg::ST_ACC) && (op_ff == sbc_pkg::OP_D1);
      d2_we          = (state_ff == sbc_pkg::ST_ACC) && (op_ff == sbc_pkg::OP_A2);
      mul_req.start  = (state_ff == sbc_pkg::ST_MUL_GO);
      mul_req.negate = 1'b0;
      mul_req.coef   = cfg.b0;
      mul_operand    = x_ff;
      unique case (op_ff)
         sbc_pkg::OP_B0: mul_req.coef = cfg.b0;
         sbc_pkg::OP_B1: mul_req.coef = cfg.b1;
         sbc_pkg::OP_B2: mul_req.coef = cfg.b2;
         sbc_pkg::OP_A1: begin
            mul_req.coef   = cfg.a1;
            mul_req.negate = 1'b1;
            mul_operand    = y_ff;
         end
         sbc_pkg::OP_A2: begin
            mul_req.coef   = cfg.a2;
            mul_req.negate = 1'b1;
            mul_operand    = y_ff;
         end
         default: mul_req.coef = cfg.b0;
      endcase
   end

   // Datapath and sequence counters.
   always_comb begin
      x_in          = x_ff;
      y_in          = y_ff;
      t_in          = t_ff;
      right_hold_in = right_hold_ff;
      left_res_in   = left_res_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      sec_in        = sec_ff;
      unique case (state_ff)
         sbc_pkg::ST_IDLE: begin
            if (in_valid) begin
               x_in          = from_sample(in_left);
               right_hold_in = in_right;
               op_in         = sbc_pkg::OP_B0;
               ch_in         = 1'b0;
               sec_in        = '0;
            end
         end
         sbc_pkg::ST_ACC: begin
            case (op_ff)
               sbc_pkg::OP_B0: begin
                  y_in  = add_sum;
                  op_in = sbc_pkg::OP_B1;
               end
               sbc_pkg::OP_B1: begin
                  t_in  = add_sum;
                  op_in = sbc_pkg::OP_A1;
               end
               sbc_pkg::OP_A1: begin
                  t_in  = add_sum;
                  op_in = sbc_pkg::OP_D1;
               end
               sbc_pkg::OP_D1: op_in = sbc_pkg::OP_B2;
               sbc_pkg::OP_B2: begin
                  t_in  = add_sum;
                  op_in = sbc_pkg::OP_A2;
               end
               sbc_pkg::OP_A2: begin
                  // section output feeds the next section
                  x_in  = y_ff;
                  op_in = sbc_pkg::OP_B0;
                  if (!sec_done) sec_in = sec_ff + SEC_W'(1);
               end
               default: op_in = sbc_pkg::OP_B0;
            endcase
         end
         sbc_pkg::ST_ROUND: begin
            if (!ch_ff) begin
               left_res_in = rnd_sample;
               x_in        = from_sample(right_hold_ff);
               ch_in       = 1'b1;
               sec_in      = '0;
            end
         end
         default: x_in = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbc_pkg::ST_IDLE;
         op_ff    <= sbc_pkg::OP_B0;
         ch_ff    <= 1'b0;
         sec_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ch_ff    <= ch_in;
         sec_ff   <= sec_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      t_ff          <= t_in;
      right_hold_ff <= right_hold_in;
      left_res_ff   <= left_res_in;
   end

   // Delay state: cleared by reset and by a first-sample transfer.
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < MAX_SECTIONS; s++) begin
               d1_ff[c][s] <= '0;
               d2_ff[c][s] <= '0;
            end
         end
      end else begin
         if (d1_we) d1_ff[ch_ff][sec_ff] <= add_sum;
         if (d2_we) d2_ff[ch_ff][sec_ff] <= add_sum;
      end
   end

   assign out_left  = left_res_ff;
   assign out_right = rnd_sample;

   `SBC_ASSERT_NOW(a_done_in_wait, clock, reset, mul_done, state_ff == sbc_pkg::ST_MUL_WAIT, "product arrived outside wait")
   `SBC_ASSERT_NEXT(a_accept_busy, clock, reset, in_accept, state_ff == sbc_pkg::ST_MUL_GO, "transfer did not start work")
   `SBC_ASSERT_NEXT(a_push_idle, clock, reset, out_push, state_ff == sbc_pkg::ST_IDLE && !ch_ff == 1'b0, "result push did not return to idle")

endmodule

// File: rtl/stereo_biquad_cascade_unit.sv
// Stereo cascade of second-order IIR sections, transposed direct form II.
//
// req_ch carries one stereo sample pair per transfer; first_sample clears all
// section delay state before that pair is filtered. rsp_ch returns one
// filtered, saturated pair per request, in order. csr_ch writes coefficient
// and section-count registers (index 0..5: b0, b1, b2, a1, a2, count); it is
// always ready and ignores unknown indexes. Write it only while idle.
//
// Both channels run through one shared 32x32 multiplier, five products per
// section and channel. Each product is issued, passes through the multiplier
// unit and is accumulated, plus one add for the first delay term. A new
// request is taken only after the result of the previous one has been pushed
// into the output register.
//
// Reset loads b0 = 1.0, the other coefficients 0, count 1, and clears all
// delay state. A result waits in the output register while rsp_ch.ready is
// low; the next request is still taken and filtered, and holds in its last
// step until the output register is free.
module stereo_biquad_cascade_unit #(
   parameter int MAX_SECTIONS = sbc_pkg::MAX_SECTIONS_DEF,
   parameter int STATE_BITS   = sbc_pkg::STATE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   sbc_req_if.sink   req_ch,
   sbc_rsp_if.source rsp_ch,
   sbc_csr_if.sink   csr_ch
);

   sbc_pkg::cfg_type     cfg_ff, cfg_in;
   sbc_pkg::mul_req_type mul_req;

   logic signed [STATE_BITS-1:0]        mul_operand, mul_product;
   logic                                mul_done, mul_busy;
   logic                                out_free, out_push;
   logic signed [sbc_pkg::SAMPLE_W-1:0] core_left, core_right;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [sbc_pkg::SAMPLE_W-1:0] left_out_ff, left_out_in;
   logic signed [sbc_pkg::SAMPLE_W-1:0] right_out_ff, right_out_in;

   // Register writes: take every transfer, drop unknown indexes.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (sbc_pkg::csr_idx_type'(csr_ch.index))
            sbc_pkg::CSR_B0:    cfg_in.b0 = csr_ch.data;
            sbc_pkg::CSR_B1:    cfg_in.b1 = csr_ch.data;
            sbc_pkg::CSR_B2:    cfg_in.b2 = csr_ch.data;
            sbc_pkg::CSR_A1:    cfg_in.a1 = csr_ch.data;
            sbc_pkg::CSR_A2:    cfg_in.a2 = csr_ch.data;
            sbc_pkg::CSR_COUNT: cfg_in.count = csr_ch.data[sbc_pkg::COUNT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.b0    <= sbc_pkg::COEF_W'(1) << sbc_pkg::COEF_FRAC;
         cfg_ff.b1    <= '0;
         cfg_ff.b2    <= '0;
         cfg_ff.a1    <= '0;
         cfg_ff.a2    <= '0;
         cfg_ff.count <= sbc_pkg::COUNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbc_core #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .STATE_BITS   (STATE_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .in_left     (req_ch.left_sample),
      .in_right    (req_ch.right_sample),
      .in_first    (req_ch.first_sample),
      .out_free    (out_free),
      .out_push    (out_push),
      .out_left    (core_left),
      .out_right   (core_right),
      .mul_req     (mul_req),
      .mul_operand (mul_operand),
      .mul_product (mul_product),
      .mul_done    (mul_done)
   );

   sbc_mul #(
      .STATE_BITS (STATE_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .operand (mul_operand),
      .product (mul_product),
      .done    (mul_done),
      .busy    (mul_busy)
   );

   // Output register: free when empty or drained in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;
      if (out_push) begin
         rsp_valid_in = 1'b1;
         left_out_in  = core_left;
         right_out_in = core_right;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      // Multiplier must be quiet once a result is pushed.
      if (out_push && mul_busy) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = left_out_ff;
   assign rsp_ch.right_out = right_out_ff;

endmodule

// File: test/sbc_filter_checker.sv
`timescale 1ns / 100ps

module sbc_filter_checker
   import sbc_pkg::*;
#(
   parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
   parameter int STATE_BITS   = STATE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   sbc_req_if   req_ch,
   sbc_rsp_if   rsp_ch,
   sbc_csr_if   csr_ch,
   output int   mismatches,
   output int   awaited,
   output int   checked
);

   localparam int     FRAC       = STATE_BITS - 24;
   localparam longint STATE_MAX  = (longint'(1) <<< (STATE_BITS - 1)) - 1;
   localparam longint STATE_MIN  = -STATE_MAX - 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } pcm_pair_type;

   cfg_type                      coefs;
   logic signed [STATE_BITS-1:0] left_d1  [MAX_SECTIONS];
   logic signed [STATE_BITS-1:0] left_d2  [MAX_SECTIONS];
   logic signed [STATE_BITS-1:0] right_d1 [MAX_SECTIONS];
   logic signed [STATE_BITS-1:0] right_d2 [MAX_SECTIONS];
   pcm_pair_type                 expected_pairs [$];
   pcm_pair_type                 want_pair;
   int                           fail_count;
   int                           result_count;

   function automatic void clear_delays();
      for (int s = 0; s < MAX_SECTIONS; s++) begin
         left_d1[s]  = '0;
         left_d2[s]  = '0;
         right_d1[s] = '0;
         right_d2[s] = '0;
      end
   endfunction

   function automatic longint sat_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > STATE_MAX) return STATE_MAX;
      if (s < STATE_MIN) return STATE_MIN;
      return s;
   endfunction

   // coef * sig / 2^30, rounded half away from zero, optionally negated, saturated
   function automatic longint scaled_term(input logic signed [COEF_W-1:0] coef,
                                          input longint sig, input bit negate);
      logic signed [127:0] wide_coef;
      logic signed [127:0] wide_sig;
      logic [127:0]        mag;
      logic [127:0]        lim;
      bit                  neg;
      wide_coef = coef;
      wide_sig  = sig;
      neg = ((sig < 0) != (coef < 0)) != negate;
      mag = (wide_sig < 0 ? -wide_sig : wide_sig) * (wide_coef < 0 ? -wide_coef : wide_coef);
      mag = (mag + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
      lim = neg ? 128'(STATE_MAX) + 128'd1 : 128'(STATE_MAX);
      if (mag > lim) mag = lim;
      return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   function automatic longint run_stage(input longint x, inout longint d1, inout longint d2);
      longint y;
      y  = sat_sum(scaled_term(coefs.b0, x, 1'b0), d1);
      d1 = sat_sum(sat_sum(scaled_term(coefs.b1, x, 1'b0), scaled_term(coefs.a1, y, 1'b1)), d2);
      d2 = sat_sum(scaled_term(coefs.b2, x, 1'b0), scaled_term(coefs.a2, y, 1'b1));
      return y;
   endfunction

   // Round half toward plus infinity, then clip to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] to_pcm(input longint y);
      longint t;
      t = sat_sum(y, longint'(1) <<< (FRAC - 1));
      t = t >>> FRAC;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t[SAMPLE_W-1:0];
   endfunction

   function automatic pcm_pair_type filter_pair(input logic signed [SAMPLE_W-1:0] l,
                                                input logic signed [SAMPLE_W-1:0] r,
                                                input logic clear);
      longint       xl, xr, dl1, dl2, dr1, dr2;
      int           n, s;
      pcm_pair_type p;
      xl = longint'(l) <<< FRAC;
      xr = longint'(r) <<< FRAC;
      if (clear) clear_delays();
      n = int'(coefs.count);
      if (n < 1) n = 1;
      if (n > MAX_SECTIONS) n = MAX_SECTIONS;
      for (s = 0; s < n; s++) begin
         dl1 = left_d1[s];
         dl2 = left_d2[s];
         dr1 = right_d1[s];
         dr2 = right_d2[s];
         xl = run_stage(xl, dl1, dl2);
         xr = run_stage(xr, dr1, dr2);
         left_d1[s]  = STATE_BITS'(dl1);
         left_d2[s]  = STATE_BITS'(dl2);
         right_d1[s] = STATE_BITS'(dr1);
         right_d2[s] = STATE_BITS'(dr2);
      end
      p.left_out  = to_pcm(xl);
      p.right_out = to_pcm(xr);
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         // b0 = 1.0, everything else zero, one section
         coefs = '{b0: 32'h4000_0000, b1: '0, b2: '0, a1: '0, a2: '0, count: 3'd1};
         clear_delays();
         expected_pairs.delete();
         fail_count   = 0;
         result_count = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_idx_type'(csr_ch.index))
               CSR_B0:    coefs.b0 = csr_ch.data;
               CSR_B1:    coefs.b1 = csr_ch.data;
               CSR_B2:    coefs.b2 = csr_ch.data;
               CSR_A1:    coefs.a1 = csr_ch.data;
               CSR_A2:    coefs.a2 = csr_ch.data;
               CSR_COUNT: coefs.count = csr_ch.data[COUNT_W-1:0];
               default:   ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pairs.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result left %0d right %0d, nothing pending",
                        $time, rsp_ch.left_out, rsp_ch.right_out);
            end else begin
               want_pair = expected_pairs.pop_front();
               result_count++;
               if (want_pair.left_out !== rsp_ch.left_out) begin
                  fail_count++;
                  $display("%0t: result %0d left_out expected %0d, got %0d", $time,
                           result_count, want_pair.left_out, rsp_ch.left_out);
               end
               if (want_pair.right_out !== rsp_ch.right_out) begin
                  fail_count++;
                  $display("%0t: result %0d right_out expected %0d, got %0d", $time,
                           result_count, want_pair.right_out, rsp_ch.right_out);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_pairs.push_back(filter_pair(req_ch.left_sample, req_ch.right_sample,
                                                 req_ch.first_sample));
      end
      mismatches <= fail_count;
      awaited    <= expected_pairs.size();
      checked    <= result_count;
   end

endmodule

// File: test/tb_stereo_biquad_cascade_unit.sv
`timescale 1ns / 100ps

module tb_stereo_biquad_cascade_unit;
   import sbc_pkg::*;

   // Random part length and the tail that runs without any idling.
   localparam int RANDOM_ITEMS    = 1300;
   localparam int CALM_ITEMS      = 150;
   // Settle wait after the last drain scales with the maximum section count.
   localparam int SETTLE_CYCLES   = 72 * MAX_SECTIONS_DEF + 20;

   localparam longint                  Q_ONE        = longint'(1) <<< COEF_FRAC;
   localparam logic [CSR_DATA_W-1:0]   COEF_MAX     = 32'h7fff_ffff;
   localparam logic [CSR_DATA_W-1:0]   COEF_MIN     = 32'h8000_0000;
   localparam logic [CSR_DATA_W-1:0]   COEF_ONE     = 32'h4000_0000;
   localparam logic [CSR_DATA_W-1:0]   COEF_NEG_ONE = 32'hc000_0000;
   localparam logic [CSR_DATA_W-1:0]   COEF_HALF    = 32'h2000_0000;
   localparam logic [CSR_DATA_W-1:0]   COEF_NEG_HALF = 32'he000_0000;
   localparam logic [CSR_DATA_W-1:0]   COEF_QUARTER = 32'h1000_0000;
   localparam logic [CSR_DATA_W-1:0]   COEF_NEG_QUARTER = 32'hf000_0000;
   localparam logic signed [SAMPLE_W-1:0] PCM_MAX   = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] PCM_MIN   = 16'sh8000;

   logic clock;
   logic reset;

   sbc_req_if req_ch ();
   sbc_rsp_if rsp_ch ();
   sbc_csr_if csr_ch ();

   int mismatches;
   int awaited;
   int checked;

   int pairs_sent;
   int settings_used;
   int target_pairs;
   int phase_len;
   int k;
   bit calm;
   int gap_pct;
   int stall_pct;

   stereo_biquad_cascade_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Watches all three channels, keeps its own filter state and scores results.
   sbc_filter_checker check_u (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .mismatches (mismatches),
      .awaited    (awaited),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop; far beyond the slowest legal run (all sections, full stalls).
   initial begin
      #(30_000_000);
      $display("** stereo_biquad_cascade_unit: FAILED **");
      $finish;
   end

   // Result side: hold ready high for a while, then drop it for a short burst.
   // Stall odds change per phase; the calm tail keeps ready high throughout.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(99, 0) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
   end

   // Leaves csr valid high so back-to-back writes never toggle it in one step;
   // the caller drops valid after the last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic apply_setting(input cfg_type c);
      write_reg(CSR_B0, c.b0);
      write_reg(CSR_B1, c.b1);
      write_reg(CSR_B2, c.b2);
      write_reg(CSR_A1, c.a1);
      write_reg(CSR_A2, c.a2);
      write_reg(CSR_COUNT, CSR_DATA_W'(c.count));
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // Valid stays high after the transfer; a gap or a drain lowers it.
   task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r,
                            input logic first);
      if (!calm && $urandom_range(99, 0) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.left_sample  <= l;
      req_ch.right_sample <= r;
      req_ch.first_sample <= first;
      do @(posedge clock); while (!req_ch.ready);
      pairs_sent++;
   endtask

   // Stop sending and wait until every predicted pair has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned w;
      w = $urandom_range(99, 0);
      if (w < 60) return SAMPLE_W'($urandom);
      if (w < 85) return SAMPLE_W'(int'($urandom_range(2048, 0)) - 1024);
      case ($urandom_range(4, 0))
         0:       return PCM_MAX;
         1:       return PCM_MIN;
         2:       return '0;
         3:       return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   // Mostly short cascades to keep the run quick; 0 and 5..7 hit the clamps.
   function automatic logic [COUNT_W-1:0] pick_count();
      int unsigned w;
      w = $urandom_range(99, 0);
      if (w < 5)  return COUNT_W'(0);
      if (w < 45) return COUNT_W'(1);
      if (w < 70) return COUNT_W'(2);
      if (w < 80) return COUNT_W'(3);
      if (w < 90) return COUNT_W'(4);
      return COUNT_W'($urandom_range(7, 5));
   endfunction

   function automatic logic [COEF_W-1:0] corner_coef();
      case ($urandom_range(4, 0))
         0:       return COEF_MIN;
         1:       return COEF_MAX;
         2:       return COEF_ONE;
         3:       return COEF_NEG_ONE;
         default: return '0;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] feedforward_coef();
      return COEF_W'(longint'($urandom_range(32'(Q_ONE), 0)) - Q_ONE / 2);
   endfunction

   // Most settings are stable sections (poles inside the stability triangle:
   // |a2| < 0.95, |a1| < 0.98 * (1 + a2)); the rest are raw or corner values
   // that drive the internal saturation hard.
   function automatic cfg_type random_setting();
      cfg_type     c;
      int unsigned style;
      longint      a2;
      longint      span;
      style = $urandom_range(99, 0);
      if (style < 65) begin
         a2   = longint'($urandom_range(32'd2_040_109_465, 0)) - 64'sd1_020_054_732;
         span = ((Q_ONE + a2) * 49) / 50;
         c.a2 = COEF_W'(a2);
         c.a1 = COEF_W'(longint'($urandom_range(32'(2 * span), 0)) - span);
         c.b0 = feedforward_coef();
         c.b1 = feedforward_coef();
         c.b2 = feedforward_coef();
      end else if (style < 85) begin
         c.b0 = $urandom;
         c.b1 = $urandom;
         c.b2 = $urandom;
         c.a1 = $urandom;
         c.a2 = $urandom;
      end else begin
         c.b0 = corner_coef();
         c.b1 = corner_coef();
         c.b2 = corner_coef();
         c.a1 = corner_coef();
         c.a2 = corner_coef();
      end
      c.count = pick_count();
      return c;
   endfunction

   initial begin
      // Known values on every input before the first edge.
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.left_sample  <= '0;
      req_ch.right_sample <= '0;
      req_ch.first_sample <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= '0;
      csr_ch.data         <= '0;
      pairs_sent    = 0;
      settings_used = 0;
      calm          = 1'b0;
      gap_pct       = 25;
      stall_pct     = 25;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients: single unity section, so samples pass straight
      // through; drive both rails and the sign boundary.
      send_pair(PCM_MAX, PCM_MIN, 1'b1);
      send_pair(PCM_MIN, PCM_MAX, 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair(-16'sd1, 16'sd1, 1'b0);
      send_pair(16'sh5555, 16'shaaaa, 1'b0);
      drain();

      // Every coefficient at a rail with four sections: saturation everywhere.
      apply_setting('{b0: COEF_MAX, b1: COEF_MIN, b2: COEF_MAX, a1: COEF_MIN,
                      a2: COEF_MAX, count: COUNT_W'(4)});
      send_pair(PCM_MAX, PCM_MIN, 1'b1);
      send_pair(PCM_MIN, PCM_MAX, 1'b0);
      send_pair(PCM_MAX, PCM_MAX, 1'b0);
      send_pair('0, '0, 1'b1);
      drain();

      // Section count zero acts as one; writes to unused indexes must not land.
      apply_setting('{b0: COEF_HALF, b1: COEF_QUARTER, b2: COEF_NEG_QUARTER,
                      a1: COEF_NEG_HALF, a2: COEF_QUARTER, count: COUNT_W'(0)});
      write_reg(CSR_IDX_W'(CSR_COUNT + 1), COEF_MAX);
      write_reg(CSR_IDX_W'(CSR_COUNT + 2), '0);
      csr_ch.valid <= 1'b0;
      send_pair(16'sd12000, -16'sd12000, 1'b1);
      send_pair('0, '0, 1'b0);
      send_pair(PCM_MIN, PCM_MAX, 1'b0);
      drain();

      // Count above the section limit clamps to all sections; the upper
      // sections start from cleared state while the first one carries history.
      apply_setting('{b0: COEF_HALF, b1: COEF_QUARTER, b2: COEF_NEG_QUARTER,
                      a1: COEF_NEG_HALF, a2: COEF_QUARTER, count: COUNT_W'(7)});
      send_pair(16'sd20000, -16'sd20000, 1'b0);
      send_pair(-16'sd5, 16'sd5, 1'b0);
      send_pair('0, '0, 1'b0);
      drain();

      // Drop to one section with b0 = -2.0, then back to four: the idle
      // sections must keep their delay state across the change.
      apply_setting('{b0: COEF_MIN, b1: COEF_QUARTER, b2: COEF_NEG_QUARTER,
                      a1: COEF_NEG_HALF, a2: COEF_QUARTER, count: COUNT_W'(1)});
      send_pair(16'sd1000, -16'sd1000, 1'b0);
      send_pair(PCM_MAX, PCM_MIN, 1'b0);
      drain();
      apply_setting('{b0: COEF_HALF, b1: COEF_QUARTER, b2: COEF_NEG_QUARTER,
                      a1: COEF_NEG_HALF, a2: COEF_QUARTER, count: COUNT_W'(4)});
      send_pair('0, '0, 1'b0);
      send_pair(16'sd100, -16'sd100, 1'b0);
      send_pair(PCM_MIN, PCM_MIN, 1'b1);
      drain();

      // Random phases: new setting while idle, then a stream of pairs. Each
      // phase boundary is also a full pause until all results are back.
      target_pairs = pairs_sent + RANDOM_ITEMS;
      while (pairs_sent < target_pairs) begin
         apply_setting(random_setting());
         if ($urandom_range(4, 0) == 0) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(50, 10);
            stall_pct = $urandom_range(50, 10);
         end
         phase_len = $urandom_range(60, 15);
         for (k = 0; k < phase_len && pairs_sent < target_pairs; k++) begin
            calm = (pairs_sent >= target_pairs - CALM_ITEMS);
            send_pair(pick_sample(), pick_sample(),
                      (k == 0) ? logic'($urandom_range(1, 0)) : ($urandom_range(49, 0) == 0));
         end
         drain();
      end

      // Give a stray late result time to show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Filtered %0d stereo pairs through %0d coefficient/section settings, %0d checked.",
               pairs_sent, settings_used, checked);
      $display("Run covered rail samples, clamped section counts, ignored register indexes,");
      $display("state clears, saturating and unstable filters, and idle/stall bursts.");
      if (mismatches == 0 && awaited == 0)
         $display("** stereo_biquad_cascade_unit: PASSED **");
      else
         $display("** stereo_biquad_cascade_unit: FAILED **");
      $finish;
   end

endmodule
